// ----- rtl/lcc_pkg.sv -----
// Shared constants, codes and control types of the Luhn card number classifier.
package lcc_pkg;

  localparam int CARD_W     = 63;
  localparam int MAX_DIGITS = 19;
  localparam int COUNT_W    = 5;
  localparam int KIND_W     = 2;
  localparam int DIGIT_W    = 4;
  localparam int STEP_W     = $clog2(CARD_W);
  localparam int IDX_W      = $clog2(MAX_DIGITS);

  typedef enum logic [KIND_W-1:0] {
    KIND_INVALID    = 2'd0,
    KIND_AMEX       = 2'd1,
    KIND_MASTERCARD = 2'd2,
    KIND_VISA       = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_WALK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic clear;
    logic convert;
    logic walk;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
  } acc_ctrl_t;

  typedef struct packed {
    kind_t              kind;
    logic               ok;
    logic [COUNT_W-1:0] count;
  } verdict_t;

endpackage

// ----- rtl/lcc_in_if.sv -----
// Input channel carrying one binary card number per item.
interface lcc_in_if;
  logic                       valid;
  logic                       ready;
  logic [lcc_pkg::CARD_W-1:0] card_number;

  modport source(output valid, output card_number, input ready);
  modport sink(input valid, input card_number, output ready);
endinterface

// ----- rtl/lcc_out_if.sv -----
// Output channel carrying one classification verdict per item.
interface lcc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lcc_pkg::KIND_W-1:0]  card_kind;
  logic                        luhn_ok;
  logic [lcc_pkg::COUNT_W-1:0] digit_count;

  modport source(output valid, output card_kind, output luhn_ok, output digit_count,
                 input ready);
  modport sink(input valid, input card_kind, input luhn_ok, input digit_count,
               output ready);
endinterface

// ----- rtl/lcc_cell.sv -----
// One decimal digit cell: shift-and-add-3 conversion step, then shifts its digit down.
module lcc_cell (
  input  logic                        clk,
  input  lcc_pkg::cell_ctrl_t         ctrl,
  input  logic                        carry_in,
  input  logic [lcc_pkg::DIGIT_W-1:0] upper,
  output logic                        carry_out,
  output logic [lcc_pkg::DIGIT_W-1:0] digit
);
  import lcc_pkg::*;

  logic [DIGIT_W-1:0] corr;

  // A digit of five or more would overflow when doubled, so it is moved ahead by three.
  assign corr      = (digit >= DIGIT_W'(5)) ? digit + DIGIT_W'(3) : digit;
  assign carry_out = corr[DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.convert) begin
      digit <= {corr[DIGIT_W-2:0], carry_in};
    end else if (ctrl.walk) begin
      digit <= upper;
    end
  end
endmodule

// ----- rtl/lcc_acc.sv -----
// Digit accumulator: Luhn sum modulo ten, digit count, leading pair and the verdict.
module lcc_acc (
  input  logic                        clk,
  input  lcc_pkg::acc_ctrl_t          ctrl,
  input  logic [lcc_pkg::DIGIT_W-1:0] digit,
  input  logic [lcc_pkg::IDX_W-1:0]   idx,
  output lcc_pkg::verdict_t           verdict
);
  import lcc_pkg::*;

  logic [DIGIT_W-1:0] sum_mod;
  logic [COUNT_W-1:0] count;
  logic [DIGIT_W-1:0] top;
  logic [DIGIT_W-1:0] second;
  logic [DIGIT_W-1:0] prev;

  logic [DIGIT_W:0]   dbl;
  logic [DIGIT_W:0]   dval;
  logic [DIGIT_W:0]   sum_tmp;
  logic [DIGIT_W-1:0] sum_mod_next;

  always_comb begin
    dbl = {digit, 1'b0};
    if (idx[0]) begin
      dval = (dbl >= (DIGIT_W+1)'(10)) ? dbl - (DIGIT_W+1)'(9) : dbl;
    end else begin
      dval = {1'b0, digit};
    end
    sum_tmp = {1'b0, sum_mod} + dval;
    if (sum_tmp >= (DIGIT_W+1)'(10)) begin
      sum_mod_next = DIGIT_W'(sum_tmp - (DIGIT_W+1)'(10));
    end else begin
      sum_mod_next = sum_tmp[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum_mod <= '0;
      count   <= '0;
      top     <= '0;
      second  <= '0;
      prev    <= '0;
    end else if (ctrl.step) begin
      sum_mod <= sum_mod_next;
      prev    <= digit;
      // The highest nonzero digit seen so far fixes the length and the leading pair.
      if (digit != '0) begin
        count  <= COUNT_W'(idx) + COUNT_W'(1);
        top    <= digit;
        second <= prev;
      end
    end
  end

  always_comb begin
    verdict.ok    = (sum_mod == '0);
    verdict.count = count;
    verdict.kind  = KIND_INVALID;
    if (verdict.ok) begin
      if (count == COUNT_W'(15)) begin
        if (top == DIGIT_W'(3) && (second == DIGIT_W'(4) || second == DIGIT_W'(7))) begin
          verdict.kind = KIND_AMEX;
        end
      end else if (count == COUNT_W'(16)) begin
        if (top == DIGIT_W'(5) && second >= DIGIT_W'(1) && second <= DIGIT_W'(5)) begin
          verdict.kind = KIND_MASTERCARD;
        end else if (top == DIGIT_W'(4)) begin
          verdict.kind = KIND_VISA;
        end
      end else if (count == COUNT_W'(13)) begin
        if (top == DIGIT_W'(4)) begin
          verdict.kind = KIND_VISA;
        end
      end
    end
  end
endmodule

// ----- rtl/luhn_card_number_classifier.sv -----
// Top level of the Luhn card number classifier: sequencer, digit cell row and verdict register.
// Each item runs through conversion (bit-serial binary to decimal, most significant bit
// first), the serial digit walk and a finish state that loads the output register when it
// is free, then returns to idle. Items are taken only in idle, one at a time.
// A new item is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) returns the sequencer to idle and empties the output.
module luhn_card_number_classifier (
  input logic clk,
  input logic rst,
  lcc_in_if.sink    card,
  lcc_out_if.source verdict
);
  import lcc_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [STEP_W-1:0]   step;
  logic [CARD_W-1:0]   bin;
  cell_ctrl_t          cell_ctrl;
  acc_ctrl_t           acc_ctrl;
  logic                accept;
  logic                load_result;
  verdict_t            acc_verdict;

  logic [DIGIT_W-1:0]  digits [MAX_DIGITS];
  logic                carries [MAX_DIGITS-1];

  assign accept = card.valid && card.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (card.valid) state_next = ST_CONV;
      ST_CONV: if (step == STEP_W'(CARD_W-1)) state_next = ST_WALK;
      ST_WALK: if (step == STEP_W'(MAX_DIGITS-1)) state_next = ST_FIN;
      ST_FIN:  if (!verdict.valid || verdict.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    card.ready        = 1'b0;
    cell_ctrl         = '0;
    acc_ctrl          = '0;
    load_result       = 1'b0;
    case (state)
      ST_IDLE: begin
        card.ready      = 1'b1;
        cell_ctrl.clear = card.valid;
        acc_ctrl.clear  = card.valid;
      end
      ST_CONV: cell_ctrl.convert = 1'b1;
      ST_WALK: begin
        cell_ctrl.walk = 1'b1;
        acc_ctrl.step  = 1'b1;
      end
      ST_FIN:  load_result = !verdict.valid || verdict.ready;
      default: card.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        step <= '0;
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

  // The binary word feeds the cell row one bit a cycle, most significant bit first.
  always_ff @(posedge clk) begin
    if (accept) begin
      bin <= card.card_number;
    end else if (cell_ctrl.convert) begin
      bin <= {bin[CARD_W-2:0], 1'b0};
    end
  end

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    logic                carry_in;
    logic [DIGIT_W-1:0]  upper;

    if (i == 0) begin : g_first
      assign carry_in = bin[CARD_W-1];
    end else begin : g_rest
      assign carry_in = carries[i-1];
    end

    if (i == MAX_DIGITS - 1) begin : g_top
      assign upper = '0;
      lcc_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .carry_in  (carry_in),
        .upper     (upper),
        .carry_out (),
        .digit     (digits[i])
      );
    end else begin : g_mid
      assign upper = digits[i+1];
      lcc_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .carry_in  (carry_in),
        .upper     (upper),
        .carry_out (carries[i]),
        .digit     (digits[i])
      );
    end
  end

  lcc_acc u_acc (
    .clk     (clk),
    .ctrl    (acc_ctrl),
    .digit   (digits[0]),
    .idx     (step[IDX_W-1:0]),
    .verdict (acc_verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (load_result) begin
      verdict.valid <= 1'b1;
    end else if (verdict.ready) begin
      verdict.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      verdict.card_kind   <= acc_verdict.kind;
      verdict.luhn_ok     <= acc_verdict.ok;
      verdict.digit_count <= acc_verdict.count;
    end
  end
endmodule
